// ===== rtl/eamt_pkg.sv =====
// ----------------------------------------------------------------------------
// eamt_pkg
// Shared types and constants for the exclusive access monitor table.
// ----------------------------------------------------------------------------
package eamt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int OWNER_BITS    = 8;
	localparam int ADDR_BITS     = 64;
	localparam int PID_BITS      = 8;
	localparam int SHIFT_BITS    = 5;

	localparam logic [SHIFT_BITS-1:0] GRANULE_SHIFT_MAX = SHIFT_BITS'(16);

	// request operation codes
	typedef enum logic [1:0] {
		MODE_TAG    = 2'd0,
		MODE_POISON = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_UNTAG  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]           mode;
		logic [ADDR_BITS-1:0] address;
		logic [PID_BITS-1:0]  cpu_id;
	} req_t;

	typedef struct packed {
		logic answer;
		logic table_full;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic commit;
	} cmd_t;

endpackage

// ===== rtl/exclusive_access_monitor_table.sv =====
// ----------------------------------------------------------------------------
// exclusive_access_monitor_table
// Global exclusive monitor: reservation table for exclusive load/store pairs.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | word
//  ---------+------------------------+------------------------------------
//  request  | start / busy           | req_t {mode, address, cpu_id}
//  result   | done (1-cycle strobe)  | res_t {answer, table_full}
//  config   | APB psel/penable/...   | granule_shift at every address
//
//  A request word is taken at an edge with start high and busy low.
//  Each request passes through latch and round, parallel tag compare over
//  all entries, then commit; done pulses in the cycle after commit and busy
//  is already low then, so the next word can be taken alongside the result.
//  A new word waits until the three controller states have run.
//  Reset clears the valid bits and the granule register; the result side
//  cannot stall, so done is never held.
//
module exclusive_access_monitor_table import eamt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  req_t        request,
	// result
	output logic        done,
	output res_t        result,
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t                  cmd;
	logic [SHIFT_BITS-1:0] granule_shift_q;

	// single register; every word address maps to it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granule_shift_q <= '0;
		end else if (psel && penable && pwrite && (paddr[1:0] == 2'd0 || 1'b1)) begin
			granule_shift_q <= pwdata[SHIFT_BITS-1:0];
		end
	end

	assign prdata = 32'(granule_shift_q);
	assign pready = 1'b1;

	eamt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	eamt_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.request       (request),
		.granule_shift (granule_shift_q),
		.done          (done),
		.result        (result)
	);

`ifndef SYNTHESIS
	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding work");

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");

	// a dropped tag never also reports an answer
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.answer && result.table_full))
		else $error("answer and table_full both set");

	// no result while a word is still in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy || $past(start && !busy))
		else $error("result overlaps work");
`endif

endmodule

// ===== rtl/eamt_ctrl.sv =====
// ----------------------------------------------------------------------------
// eamt_ctrl
// Request sequencer: accept, match, commit.
// ----------------------------------------------------------------------------
module eamt_ctrl import eamt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EVAL   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.eval   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/eamt_datapath.sv =====
// ----------------------------------------------------------------------------
// eamt_datapath
// Reservation table, request registers, parallel match and update.
// ----------------------------------------------------------------------------
module eamt_datapath import eamt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  req_t                  request,
	input  logic [SHIFT_BITS-1:0] granule_shift,
	output logic                  done,
	output res_t                  result
);

	// table
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] poisoned_q;
	logic [ADDR_BITS-1:0]     entry_addr_q  [TABLE_ENTRIES];
	logic [OWNER_BITS-1:0]    entry_owner_q [TABLE_ENTRIES];

	// request word
	logic [1:0]            req_mode_q;
	logic [ADDR_BITS-1:0]  req_addr_q;
	logic [OWNER_BITS-1:0] req_owner_q;

	// match stage
	logic [TABLE_ENTRIES-1:0] hit_s1;
	logic [TABLE_ENTRIES-1:0] own_s1;
	logic [TABLE_ENTRIES-1:0] free_s1;
	logic                     full_s1;

	logic                  done_q;
	res_t                  res_q;

	logic [SHIFT_BITS-1:0] shift_eff;
	logic [ADDR_BITS-1:0]  round_mask;

	always_comb begin
		shift_eff = (granule_shift > GRANULE_SHIFT_MAX) ? GRANULE_SHIFT_MAX : granule_shift;
		for (int b = 0; b < ADDR_BITS; b++) begin
			round_mask[b] = (b >= int'(shift_eff));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_mode_q  <= request.mode;
			req_addr_q  <= request.address & round_mask;
			req_owner_q <= request.cpu_id[OWNER_BITS-1:0];
		end
	end

	// parallel compare; lowest free slot as a one-hot word
	logic [TABLE_ENTRIES-1:0] hit_d, own_d, free_vec;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_d[i] = valid_q[i] && (entry_addr_q[i] == req_addr_q);
			own_d[i] = (entry_owner_q[i] == req_owner_q);
		end
		free_vec = ~valid_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			hit_s1  <= hit_d;
			own_s1  <= own_d;
			free_s1 <= free_vec & (~free_vec + TABLE_ENTRIES'(1));
			full_s1 <= &valid_q;
		end
	end

	// commit
	logic hit_any, own_hit, pois_hit;
	res_t res_d;
	logic do_alloc;

	always_comb begin
		hit_any  = |hit_s1;
		own_hit  = |(hit_s1 & own_s1);
		pois_hit = |(hit_s1 & own_s1 & poisoned_q);
		do_alloc = 1'b0;
		res_d    = '0;
		unique case (mode_t'(req_mode_q))
			MODE_TAG: begin
				if (!hit_any) begin
					if (full_s1) begin
						res_d.table_full = 1'b1;
					end else begin
						do_alloc = 1'b1;
					end
				end
			end
			MODE_POISON: begin
				res_d.answer = hit_any;
			end
			MODE_QUERY: begin
				res_d.answer = !own_hit || pois_hit;
			end
			MODE_UNTAG: begin
				res_d.answer = 1'b0;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				if (do_alloc) begin
					valid_q <= valid_q | free_s1;
				end else if (mode_t'(req_mode_q) == MODE_UNTAG) begin
					valid_q <= valid_q & ~(hit_s1 & own_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= res_d;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (do_alloc && free_s1[i]) begin
					entry_addr_q[i]  <= req_addr_q;
					entry_owner_q[i] <= req_owner_q;
					poisoned_q[i]    <= 1'b0;
				end else if (mode_t'(req_mode_q) == MODE_POISON && hit_s1[i]) begin
					poisoned_q[i] <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the exclusive access monitor table. A directed
// table of requests covers the corner cases, then random request streams run
// under several granule settings; each result word is compared with a typed-in
// expectation or a local model of the reservation table.
// ----------------------------------------------------------------------------
module tb;
	import eamt_pkg::*;

	localparam logic [1:0] REG_GRANULE_SHIFT = 2'd0;
	localparam int POOL_SIZE   = 20;
	localparam int PHASE_ITEMS = 135;
	localparam int NUM_PHASES  = 7;

	localparam res_t RES_NONE = '{answer: 1'b0, table_full: 1'b0};
	localparam res_t RES_ANS  = '{answer: 1'b1, table_full: 1'b0};
	localparam res_t RES_FULL = '{answer: 1'b0, table_full: 1'b1};

	// one directed row; reps > 1 repeats it with the address stepped by 16
	typedef struct {
		mode_t       mode;
		logic [63:0] address;
		logic [7:0]  pid;
		int          reps;
		bit          typed;
		res_t        want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	logic        done;
	res_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// travels with the request word: use a typed-in expectation instead of the model
	logic typed_next;
	res_t typed_want;

	// local copy of the reservation table and granule register
	logic                  resv_valid    [TABLE_ENTRIES];
	logic [ADDR_BITS-1:0]  resv_addr     [TABLE_ENTRIES];
	logic [OWNER_BITS-1:0] resv_owner    [TABLE_ENTRIES];
	logic                  resv_poisoned [TABLE_ENTRIES];
	logic [SHIFT_BITS-1:0] granule_q;

	res_t expected_results[$];

	logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
	logic [PID_BITS-1:0]  pid_pool  [4];

	plan_row_t plan[$];

	int errors      = 0;
	int n_requests  = 0;
	int n_results   = 0;
	int n_answers   = 0;
	int n_full      = 0;
	int n_settings  = 0;
	int n_random    = 0;

	exclusive_access_monitor_table uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// granule shift as applied: anything above 16 clamps to 16
	function automatic int granule_bits();
		return (granule_q > GRANULE_SHIFT_MAX) ? 16 : int'(granule_q);
	endfunction

	// Applies one request to the local table and returns the result word it gives.
	function automatic res_t predict_reservation(req_t rq);
		logic [ADDR_BITS-1:0]  ra;
		logic [OWNER_BITS-1:0] own;
		int                    hit;
		int                    slot;
		res_t                  r;
		ra   = rq.address & ~((64'd1 << granule_bits()) - 64'd1);
		own  = rq.cpu_id[OWNER_BITS-1:0];
		hit  = -1;
		slot = -1;
		r    = RES_NONE;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit < 0 && resv_valid[i] && resv_addr[i] == ra)
				hit = i;
			if (slot < 0 && !resv_valid[i])
				slot = i;
		end
		case (rq.mode)
			MODE_TAG: begin
				// an existing reservation is left untouched, owner and mark included
				if (hit < 0) begin
					if (slot < 0) begin
						r.table_full = 1'b1;
					end else begin
						resv_valid[slot]    = 1'b1;
						resv_addr[slot]     = ra;
						resv_owner[slot]    = own;
						resv_poisoned[slot] = 1'b0;
					end
				end
			end
			MODE_POISON: begin
				if (hit >= 0) begin
					resv_poisoned[hit] = 1'b1;
					r.answer = 1'b1;
				end
			end
			MODE_QUERY: begin
				if (hit < 0 || resv_owner[hit] != own)
					r.answer = 1'b1;
				else
					r.answer = resv_poisoned[hit];
			end
			MODE_UNTAG: begin
				if (hit >= 0 && resv_owner[hit] == own)
					resv_valid[hit] = 1'b0;
			end
		endcase
		return r;
	endfunction

	// Random request: mostly pool addresses and pool processors so that
	// reservations are hit, owned, poisoned and released; some pure noise.
	function automatic req_t random_request();
		req_t rq;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 35)
			rq.mode = MODE_TAG;
		else if (pick < 50)
			rq.mode = MODE_POISON;
		else if (pick < 80)
			rq.mode = MODE_QUERY;
		else
			rq.mode = MODE_UNTAG;
		if ($urandom_range(99) < 10) begin
			rq.address = {$urandom, $urandom};
		end else begin
			rq.address = addr_pool[$urandom_range(POOL_SIZE-1)];
			case ($urandom_range(2))
				// offset inside the current granule: rounds back onto the pool address
				1: rq.address = rq.address | 64'($urandom & ((32'd1 << granule_bits()) - 1));
				2: rq.address = rq.address | 64'($urandom_range(17'h1ffff));
				default: ;
			endcase
		end
		if ($urandom_range(99) < 15)
			rq.cpu_id = PID_BITS'($urandom);
		else
			rq.cpu_id = pid_pool[$urandom_range(3)];
		return rq;
	endfunction

	// Result check and prediction, both on the same edge in one process:
	// the result word is retired first, then any newly taken request word.
	always @(posedge clk) begin : result_check
		res_t want;
		res_t pred;
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result answer=%0b table_full=%0b",
						$time, result.answer, result.table_full);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.answer !== want.answer || result.table_full !== want.table_full) begin
						$display("%0t: mismatch expected answer=%0b table_full=%0b, got answer=%0b table_full=%0b",
							$time, want.answer, want.table_full, result.answer, result.table_full);
						errors++;
					end
					if (result.answer === 1'b1)
						n_answers++;
					if (result.table_full === 1'b1)
						n_full++;
				end
			end
			if (start && !busy) begin
				n_requests++;
				pred = predict_reservation(request);
				expected_results.push_back(typed_next ? typed_want : pred);
			end
		end
	end

	// Drives one request word and returns at the edge that takes it.
	task automatic issue_request(input req_t rq, input bit typed, input res_t want,
			input bit may_idle);
		if (may_idle && $urandom_range(99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start      <= 1'b1;
		request    <= rq;
		typed_next <= typed;
		typed_want <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Stop sending and wait for every outstanding result; the extra edge lets
	// the word taken at the last edge reach the expected queue first.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// One APB transfer to the granule register; read data taken mid access phase.
	// Ends with psel and penable dropped and the bus idle.
	task automatic apb_access(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_GRANULE_SHIFT;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(negedge clk);
			if (pready === 1'b1)
				break;
		end
		rdata = prdata;
		@(posedge clk);
		if (wr)
			granule_q = wdata[SHIFT_BITS-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_granule(input logic [SHIFT_BITS-1:0] g);
		logic [31:0] rd;
		apb_access(1'b1, 32'(g), rd);
		apb_access(1'b0, 32'd0, rd);
		if (rd[SHIFT_BITS-1:0] !== g) begin
			$display("%0t: granule readback expected %0d, got %0d",
				$time, g, rd[SHIFT_BITS-1:0]);
			errors++;
		end
		n_settings++;
	endtask

	// Owner releases every live reservation; ones no longer reachable under
	// the current granule just stay put.
	task automatic release_all();
		req_t rq;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (resv_valid[i]) begin
				rq.mode    = MODE_UNTAG;
				rq.address = resv_addr[i];
				rq.cpu_id  = resv_owner[i];
				issue_request(rq, 1'b0, RES_NONE, 1'b1);
			end
		end
	endtask

	initial begin : stimulus
		req_t                  rq;
		logic [31:0]           rd;
		logic [SHIFT_BITS-1:0] phase_granule [NUM_PHASES];
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		typed_next = 1'b0;
		typed_want = RES_NONE;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = REG_GRANULE_SHIFT;
		pwdata     = '0;
		granule_q  = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			resv_valid[i]    = 1'b0;
			resv_addr[i]     = '0;
			resv_owner[i]    = '0;
			resv_poisoned[i] = 1'b0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = {$urandom, $urandom} & ~64'h1ffff;
		pid_pool = '{8'h00, 8'hff, 8'h5a, 8'h81};
		// extremes first, then a mix; last one is drawn at random
		phase_granule = '{5'd31, 5'd16, 5'd0, 5'd17, 5'd1, 5'd12,
			SHIFT_BITS'($urandom_range(31))};

		// all at granule 0 straight out of reset
		plan = '{
			'{MODE_QUERY,  64'h0,    8'h00, 1, 1'b1, RES_ANS},   // empty table: lost
			'{MODE_POISON, 64'h1000, 8'h00, 1, 1'b1, RES_NONE},  // poison of nothing
			'{MODE_UNTAG,  64'h1000, 8'h05, 1, 1'b1, RES_NONE},  // untag of nothing
			'{MODE_TAG,    64'h0,    8'h00, 1, 1'b1, RES_NONE},
			'{MODE_QUERY,  64'h0,    8'h00, 1, 1'b1, RES_NONE},
			'{MODE_QUERY,  64'h0,    8'hff, 1, 1'b1, RES_ANS},   // other owner
			'{MODE_TAG,    64'h0,    8'hff, 1, 1'b1, RES_NONE},  // already tagged
			'{MODE_QUERY,  64'h0,    8'h00, 1, 1'b1, RES_NONE},  // owner kept
			'{MODE_POISON, 64'h0,    8'h07, 1, 1'b1, RES_ANS},
			'{MODE_TAG,    64'h0,    8'h00, 1, 1'b1, RES_NONE},  // retag keeps mark
			'{MODE_QUERY,  64'h0,    8'h00, 1, 1'b1, RES_ANS},
			'{MODE_UNTAG,  64'h0,    8'hff, 1, 1'b1, RES_NONE},  // not the owner
			'{MODE_QUERY,  64'h0,    8'h00, 1, 1'b1, RES_ANS},
			'{MODE_UNTAG,  64'h0,    8'h00, 1, 1'b1, RES_NONE},
			'{MODE_QUERY,  64'h0,    8'h00, 1, 1'b1, RES_ANS},   // released
			'{MODE_TAG,    64'hffff_ffff_ffff_ffff, 8'hff, 1, 1'b1, RES_NONE},
			'{MODE_QUERY,  64'hffff_ffff_ffff_ffff, 8'hff, 1, 1'b1, RES_NONE},
			'{MODE_TAG,    64'h100,  8'h12, 15, 1'b0, RES_NONE}, // fills the table
			'{MODE_TAG,    64'h5000, 8'h34, 1, 1'b1, RES_FULL},  // dropped
			'{MODE_QUERY,  64'h5000, 8'h34, 1, 1'b1, RES_ANS},
			'{MODE_UNTAG,  64'h140,  8'h12, 1, 1'b0, RES_NONE},  // frees a middle slot
			'{MODE_TAG,    64'h5000, 8'h34, 1, 1'b0, RES_NONE},  // lowest free slot
			'{MODE_POISON, 64'h5000, 8'h00, 1, 1'b0, RES_NONE},
			'{MODE_QUERY,  64'h5000, 8'h34, 1, 1'b0, RES_NONE},
			'{MODE_QUERY,  64'haaaa_5555_aaaa_5555, 8'haa, 1, 1'b0, RES_NONE}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// granule register must come out of reset as 0
		apb_access(1'b0, 32'd0, rd);
		if (rd[SHIFT_BITS-1:0] !== '0) begin
			$display("%0t: granule after reset expected 0, got %0d",
				$time, rd[SHIFT_BITS-1:0]);
			errors++;
		end

		foreach (plan[r]) begin
			for (int k = 0; k < plan[r].reps; k++) begin
				rq.mode    = plan[r].mode;
				rq.address = plan[r].address + 64'(k * 16);
				rq.cpu_id  = plan[r].pid;
				issue_request(rq, plan[r].typed, plan[r].want, 1'b1);
			end
		end
		settle();
		release_all();
		settle();

		// random phases; entries left from an older granule carry over on purpose
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_granule(phase_granule[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// a long stretch in the middle runs back to back
				issue_request(random_request(), 1'b0, RES_NONE,
					!(n_random >= 300 && n_random < 520));
				n_random++;
			end
			settle();
			release_all();
			settle();
		end

		repeat (6) @(posedge clk);
		$display("tb: %0d requests under %0d granule settings, %0d result words checked",
			n_requests, n_settings, n_results);
		$display("tb: %0d with answer set, %0d tags dropped on a full table, %0d errors",
			n_answers, n_full, errors);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/eamt_pkg.sv
rtl/eamt_ctrl.sv
rtl/eamt_datapath.sv
rtl/exclusive_access_monitor_table.sv
tb/tb.sv
